// ===== hdl/fpdiv_pkg.sv =====
// types, constants and a helper function shared by the fp32 divider
package fpdiv_pkg;

   localparam int SIG_W  = 24;
   localparam int QUO_W  = 26;
   localparam int STEPS  = 26;
   localparam int EXP_W  = 11;

   localparam logic [31:0] MAG_MASK = 32'h7FFF_FFFF;
   localparam logic [31:0] INF_BITS = 32'h7F80_0000;
   localparam logic [31:0] MAX_FIN  = 32'h7F7F_FFFF;
   localparam logic [31:0] QNAN_BIT = 32'h0040_0000;

   localparam int FLAG_INVALID  = 0;
   localparam int FLAG_DIVZERO  = 1;
   localparam int FLAG_OVERFLOW = 2;
   localparam int FLAG_INEXACT  = 3;

   // data carried along the row of divider cells
   typedef struct packed {
      logic              valid;
      logic              special;
      logic [31:0]       spec_res;
      logic [3:0]        spec_flags;
      logic              sign;
      logic signed [EXP_W-1:0] exp;
      logic [SIG_W:0]    rem;
      logic [SIG_W-1:0]  div;
      logic [QUO_W-1:0]  quo;
   } cell_type;

   function automatic logic [4:0] lzc32(input logic [31:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 5'(31 - i);
      end
      return n;
   endfunction

endpackage

// ===== hdl/fp32_divider_unit.sv =====
// fp32 divider top level: decode, row of division cells, rounding and output register
//
//  channel | ports        | payload
//  request | req_t*       | tdata = dividend[31:0], divisor[63:32]
//  result  | rsp_t*       | tdata = quotient[31:0], exception_flags[35:32]
//
// one transaction per cycle when not stalled; 26 division cells plus output register
// each cell produces one quotient bit, the row length sets the latency
// the whole row advances together; a stalled result holds the row
// reset clears valid bits only
module fp32_divider_unit
   import fpdiv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // dividend, divisor
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // quotient, exception_flags, zero fill
);

   cell_type    chain [STEPS+1];
   logic        advance;
   logic        out_valid_ff;
   logic [35:0] out_data_ff;
   logic [31:0] quo_w;
   logic [3:0]  flg_w;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   fpdiv_unpack u_unpack (
      .valid   (req_tvalid),
      .x       (req_tdata[31:0]),
      .y       (req_tdata[63:32]),
      .cell_out(chain[0])
   );

   for (genvar g = 0; g < STEPS; g++) begin : g_cell
      fpdiv_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (advance),
         .cell_in (chain[g]),
         .cell_out(chain[g+1])
      );
   end

   fpdiv_round u_round (
      .cell_in (chain[STEPS]),
      .quotient(quo_w),
      .flags   (flg_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[STEPS].valid;
      end
      if (advance) begin
         out_data_ff <= {flg_w, quo_w};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_data_ff};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipe stalled with empty output");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34] |-> rsp_tdata[35])
      else $error("overflow without inexact");

endmodule

// ===== hdl/fpdiv_cell.sv =====
// one restoring division step, registered
module fpdiv_cell
   import fpdiv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  cell_type cell_in,
   output cell_type cell_out
);

   cell_type cell_ff;
   cell_type cell_in_w;
   logic [SIG_W+1:0] diff;

   always_comb begin
      cell_in_w = cell_in;
      diff = {1'b0, cell_in.rem} - {2'b00, cell_in.div};
      if (!diff[SIG_W+1]) begin
         cell_in_w.rem = {diff[SIG_W-1:0], 1'b0};
         cell_in_w.quo = {cell_in.quo[QUO_W-2:0], 1'b1};
      end else begin
         cell_in_w.rem = {cell_in.rem[SIG_W-1:0], 1'b0};
         cell_in_w.quo = {cell_in.quo[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (enable) begin
         cell_ff.special    <= cell_in_w.special;
         cell_ff.spec_res   <= cell_in_w.spec_res;
         cell_ff.spec_flags <= cell_in_w.spec_flags;
         cell_ff.sign       <= cell_in_w.sign;
         cell_ff.exp        <= cell_in_w.exp;
         cell_ff.rem        <= cell_in_w.rem;
         cell_ff.div        <= cell_in_w.div;
         cell_ff.quo        <= cell_in_w.quo;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== hdl/fpdiv_unpack.sv =====
// operand decode, special cases and significand normalisation
module fpdiv_unpack
   import fpdiv_pkg::*;
(
   input  logic        valid,
   input  logic [31:0] x,
   input  logic [31:0] y,
   output cell_type    cell_out
);

   logic [31:0] ax, ay, mx, inf, ax_m1, ay_m1;
   logic [31:0] sgn;
   logic [4:0]  lzx, lzy;
   logic [31:0] nx, ny;
   logic signed [EXP_W-1:0] ex, ey;
   logic [SIG_W-1:0] sx, sy;

   always_comb begin
      ax    = x & MAG_MASK;
      ay    = y & MAG_MASK;
      sgn   = {x[31] ^ y[31], 31'd0};
      inf   = sgn | INF_BITS;
      mx    = (ax > ay) ? ax : ay;
      ax_m1 = ax - 32'd1;
      ay_m1 = ay - 32'd1;
      lzx   = lzc32(ax);
      lzy   = lzc32(ay);
      nx    = ax << (lzx - 5'd8);
      ny    = ay << (lzy - 5'd8);
      if (ax[30:23] == 8'd0) begin
         sx = nx[SIG_W-1:0];
         ex = EXP_W'(9) - EXP_W'(lzx);
      end else begin
         sx = {1'b1, ax[22:0]};
         ex = EXP_W'(ax[30:23]);
      end
      if (ay[30:23] == 8'd0) begin
         sy = ny[SIG_W-1:0];
         ey = EXP_W'(9) - EXP_W'(lzy);
      end else begin
         sy = {1'b1, ay[22:0]};
         ey = EXP_W'(ay[30:23]);
      end

      cell_out            = '0;
      cell_out.valid      = valid;
      cell_out.sign       = sgn[31];
      cell_out.special    = (ax_m1 >= MAX_FIN) || (ay_m1 >= MAX_FIN);
      cell_out.div        = sy;
      cell_out.rem        = {1'b0, sx};
      cell_out.exp        = ex - ey + EXP_W'(127);
      if (sx < sy) begin
         cell_out.rem = {sx, 1'b0};
         cell_out.exp = ex - ey + EXP_W'(126);
      end
      if (mx > INF_BITS || ax == ay) begin
         cell_out.spec_res = inf | QNAN_BIT | mx;
         cell_out.spec_flags[FLAG_INVALID] =
            (ax > INF_BITS && !x[22]) || (ay > INF_BITS && !y[22]) ||
            (ax == INF_BITS && ay == INF_BITS) || (ax == 32'd0 && ay == 32'd0);
      end else if (ax < ay) begin
         cell_out.spec_res = sgn;
      end else begin
         cell_out.spec_res = inf;
         cell_out.spec_flags[FLAG_DIVZERO] = (ax != INF_BITS) && (ay == 32'd0);
      end
   end

endmodule

// ===== hdl/fpdiv_round.sv =====
// subnormal shift, rounding to nearest even and overflow detection
module fpdiv_round
   import fpdiv_pkg::*;
(
   input  cell_type    cell_in,
   output logic [31:0] quotient,
   output logic [3:0]  flags
);

   logic [QUO_W-1:0] q;
   logic             sticky, guard, rest, up;
   logic [4:0]       sh;
   logic [QUO_W-1:0] lost_mask;
   logic [7:0]       base;
   logic [31:0]      word;
   logic signed [EXP_W-1:0] sh_full;

   always_comb begin
      q         = cell_in.quo;
      sticky    = cell_in.rem != '0;
      sh_full   = EXP_W'(1) - cell_in.exp;
      sh        = 5'd0;
      base      = 8'd0;
      lost_mask = '0;
      flags     = '0;
      quotient  = '0;
      if (cell_in.exp < EXP_W'(1)) begin
         sh = (sh_full > EXP_W'(27)) ? 5'd27 : sh_full[4:0];
         lost_mask = QUO_W'((27'd1 << sh) - 27'd1);
         if ((q & lost_mask) != '0) sticky = 1'b1;
         q = QUO_W'({1'b0, q} >> sh);
      end else begin
         base = 8'(cell_in.exp - EXP_W'(1));
      end
      guard = q[1];
      rest  = q[0] | sticky;
      up    = guard & (rest | q[2]);
      word  = {1'b0, base, 23'd0} + {8'd0, q[QUO_W-1:2]} + {31'd0, up};
      if (cell_in.special) begin
         quotient = cell_in.spec_res;
         flags    = cell_in.spec_flags;
      end else if (cell_in.exp >= EXP_W'(255) || word >= INF_BITS) begin
         quotient = {cell_in.sign, INF_BITS[30:0]};
         flags[FLAG_OVERFLOW] = 1'b1;
         flags[FLAG_INEXACT]  = 1'b1;
      end else begin
         quotient = {cell_in.sign, word[30:0]};
         flags[FLAG_INEXACT] = guard | rest;
      end
   end

endmodule
